### rtl/core/aes256_block_decrypt_unit_defines.svh
// assertion macros shared by the decrypt core
`ifndef AES256_BLOCK_DECRYPT_UNIT_DEFINES_SVH
`define AES256_BLOCK_DECRYPT_UNIT_DEFINES_SVH
// implication checked on every edge outside reset
`define AD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define AD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/core/aesd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aesd_pkg;
    localparam int NumRounds = 14;
    localparam int NumCells  = NumRounds + 1;
    localparam int LatCycles = NumCells + 1;

    // cycles from a key change until the last window of the schedule is valid
    localparam logic [3:0] KeySettleCycles = 4'd8;

    localparam logic [1:0] KeyIdx0 = 2'd0;
    localparam logic [1:0] KeyIdx1 = 2'd1;
    localparam logic [1:0] KeyIdx2 = 2'd2;
    localparam logic [1:0] KeyIdx3 = 2'd3;

    localparam logic [7:0] XtimePoly = 8'h1b;

    // data handed from one cell to the next
    typedef struct packed {
        logic         vld;
        logic [127:0] state;
    } cell_bus_t;

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] r;
        case (x)
            8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
            8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
            8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
            8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
            8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
            8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
            8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
            8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
            8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
            8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
            8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
            8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
            8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
            8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
            8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
            8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
            8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
            8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
            8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
            8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
            8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
            8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
            8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
            8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
            8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
            8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
            8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
            8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
            8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
            8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
            8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
            8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
            8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
            8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
            8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
            8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
            8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
            8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
            8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
            8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
            8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
            8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
            8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
            8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
            8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
            8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
            8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
            8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
            8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
            8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
            8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
            8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
            8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
            8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
            8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
            8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
            8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
            8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
            8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
            8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
            8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
            8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
            8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
            8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; default: r=8'h7d;
        endcase
        return r;
    endfunction

    // forward s-box as the inverse of the inverse table
    function automatic logic [7:0] fwd_sbox(input logic [7:0] x);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 256; i++) begin
            if (inv_sbox(8'(i)) == x) begin
                r = 8'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? XtimePoly : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {fwd_sbox(w[31:24]), fwd_sbox(w[23:16]), fwd_sbox(w[15:8]), fwd_sbox(w[7:0])};
    endfunction

    // inverse mix of one column, bytes a0 (msb) .. a3
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int i = 0; i < 4; i++) begin
            a[i]  = c[31-8*i -: 8];
            x2[i] = xtime(a[i]);
            x4[i] = xtime(x2[i]);
            x8[i] = xtime(x4[i]);
            m9[i] = x8[i] ^ a[i];
            mb[i] = x8[i] ^ x2[i] ^ a[i];
            md[i] = x8[i] ^ x4[i] ^ a[i];
            me[i] = x8[i] ^ x4[i] ^ x2[i];
        end
        return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

    // inverse shift rows then inverse s-box; byte k = row k%4, column k/4
    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        logic [127:0] t;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[127-8*(r+4*c) -: 8] = inv_sbox(s[127-8*(r+4*((c-r+4)%4)) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        return {inv_mix_col(s[127:96]), inv_mix_col(s[95:64]),
                inv_mix_col(s[63:32]), inv_mix_col(s[31:0])};
    endfunction
endpackage
`default_nettype wire

### rtl/core/aesd_key_sched.sv
`timescale 1ns / 1ps
`default_nettype none
// key schedule: registered round keys, one step of eight words per cycle
module aesd_key_sched (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [255:0] key,
    output logic [127:0]      round_key [aesd_pkg::NumCells]
);
    // eight-word windows of the schedule, window j holds words 8j..8j+7
    logic [255:0] win_reg  [8];
    logic [255:0] win_next [8];
    logic [7:0]   rcon     [8];

    always_comb
    begin
        rcon[0] = 8'h01;
        for (int j = 1; j < 8; j++) begin
            rcon[j] = aesd_pkg::xtime(rcon[j-1]);
        end
    end

    // each window built from the previous registered window
    always_comb
    begin
        logic [31:0] w [16];
        logic [31:0] t;
        win_next[0] = key;
        for (int j = 1; j < 8; j++) begin
            for (int i = 0; i < 8; i++) begin
                w[i] = win_reg[j-1][255-32*i -: 32];
            end
            for (int i = 8; i < 16; i++) begin
                t = w[i-1];
                if (i == 8) begin
                    t = aesd_pkg::sub_word({t[23:0], t[31:24]}) ^ {rcon[j-1], 24'h0};
                end else if (i == 12) begin
                    t = aesd_pkg::sub_word(t);
                end
                w[i] = w[i-8] ^ t;
            end
            for (int i = 0; i < 8; i++) begin
                win_next[j][255-32*i -: 32] = w[i+8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int j = 0; j < 8; j++) begin
                win_reg[j] <= '0;
            end
        end else begin
            for (int j = 0; j < 8; j++) begin
                win_reg[j] <= win_next[j];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < aesd_pkg::NumCells; k++) begin
            round_key[k] = (k % 2 == 0) ? win_reg[k/2][255:128] : win_reg[k/2][127:0];
        end
    end
endmodule
`default_nettype wire

### rtl/core/aesd_round_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// one inverse round; first cell only adds the key, last skips mix columns
module aesd_round_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                first,
    input  wire logic                last,
    input  wire logic [127:0]        round_key,
    input  wire aesd_pkg::cell_bus_t din,
    output aesd_pkg::cell_bus_t      dout
);
    logic         vld_reg;
    logic [127:0] state_reg;
    logic [127:0] state_next;

    // round datapath
    always_comb
    begin
        logic [127:0] t;
        t = aesd_pkg::inv_shift_sub(din.state) ^ round_key;
        if (first) begin
            state_next = din.state ^ round_key;
        end else begin
            state_next = last ? t : aesd_pkg::inv_mix(t);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= din.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign dout.vld   = vld_reg;
    assign dout.state = state_reg;
endmodule
`default_nettype wire

### rtl/core/aes256_block_decrypt_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// AES-256 block decrypt, ECB, unrolled chain of round cells.
// config: write key_word_0..3 through cfg_we/cfg_idx/cfg_data while idle;
// all four indexes map to a key word.
// the round key schedule is a pipeline of 8 registered windows, so the round
// keys settle after a key write has passed every window; busy is high while
// they settle; new starts are held off until the keys match the written key.
// input: a transaction is taken on each clock edge with start high and busy
// low; outside the settle window one block is accepted every cycle.
// output: done pulses for one cycle with plain_hi/plain_lo once the block
// has passed the input register and the 15 round cells. throughput is one
// block per cycle while busy is low, set by the cell chain.
// results keep input order. the receiver cannot stall; each result is shown
// exactly once. reset clears the key to zero, drops any block in flight and
// holds busy high while the zero-key schedule settles.
`include "aes256_block_decrypt_unit_defines.svh"
module aes256_block_decrypt_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_idx,
    input  wire logic [63:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] cipher_hi,
    input  wire logic [63:0] cipher_lo,
    output logic             done,
    output logic [63:0]      plain_hi,
    output logic [63:0]      plain_lo
);
    logic [63:0]         key_reg [4];
    logic [127:0]        round_key [aesd_pkg::NumCells];
    aesd_pkg::cell_bus_t bus [aesd_pkg::NumCells + 1];
    logic                in_vld_reg;
    logic [127:0]        in_reg;
    logic [3:0]          settle_reg;

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 4; i++) begin
                key_reg[i] <= 64'h0;
            end
        end else if (cfg_we) begin
            unique case (cfg_idx)
                aesd_pkg::KeyIdx0: key_reg[0] <= cfg_data;
                aesd_pkg::KeyIdx1: key_reg[1] <= cfg_data;
                aesd_pkg::KeyIdx2: key_reg[2] <= cfg_data;
                aesd_pkg::KeyIdx3: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // settle count of the key schedule pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            settle_reg <= aesd_pkg::KeySettleCycles;
        end else if (cfg_we) begin
            settle_reg <= aesd_pkg::KeySettleCycles;
        end else if (settle_reg != 4'd0) begin
            settle_reg <= settle_reg - 4'd1;
        end
    end

    assign busy = (settle_reg != 4'd0);

    aesd_key_sched u_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .round_key (round_key)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg <= {cipher_hi, cipher_lo};
    end

    assign bus[0].vld   = in_vld_reg;
    assign bus[0].state = in_reg;

    // cell k uses round key 14-k
    for (genvar k = 0; k < aesd_pkg::NumCells; k++) begin : g_cell
        aesd_round_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .first     (k == 0),
            .last      (k == aesd_pkg::NumCells - 1),
            .round_key (round_key[aesd_pkg::NumRounds - k]),
            .din       (bus[k]),
            .dout      (bus[k+1])
        );
    end

    assign done     = bus[aesd_pkg::NumCells].vld;
    assign plain_hi = bus[aesd_pkg::NumCells].state[127:64];
    assign plain_lo = bus[aesd_pkg::NumCells].state[63:0];

    `AD_ASSERT_NEXT(a_in_vld, start && !busy, in_vld_reg)
    `AD_ASSERT_NEXT(a_first_cell, in_vld_reg, bus[1].vld)
    `AD_ASSERT_IMPL(a_done_lat, done, $past(start && !busy, aesd_pkg::LatCycles))
    `AD_ASSERT_NEXT(a_cfg_busy, cfg_we, busy)
endmodule
`default_nettype wire
